// ===== hdl/ltc_pkg.sv =====
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared constants, types and helpers of the line position centroid tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ltc_pkg;

    localparam int SensorCount = 8;
    localparam int SampleW     = 10;
    localparam int MaskW       = 8;
    localparam int CountW      = $clog2(SensorCount + 1);
    localparam int WsumW       = $clog2(SensorCount * SensorCount) + 2;
    localparam int MagW        = WsumW - 1;
    localparam int DenW        = $clog2(SensorCount * (SensorCount - 1) + 1);
    localparam int RemW        = DenW + 1;
    localparam int TimeW       = 32;
    localparam int ThrW        = 10;
    localparam int ToW         = 16;
    localparam int PosW        = 16;
    localparam int FracBits    = 14;
    localparam int QW          = FracBits + 1;
    localparam int DivSteps    = 4;
    localparam int DivCycles   = 4;
    localparam int QuoW        = DivSteps * DivCycles;
    localparam int StepW       = $clog2(DivCycles);
    localparam int FifoDepth   = 2;
    localparam int PtrW        = $clog2(FifoDepth);
    localparam int LevelW      = $clog2(FifoDepth + 1);
    localparam int CfgIdxW     = 1;
    localparam int CfgDataW    = 16;

    localparam logic [QW-1:0] QOne = QW'(1 << FracBits);

    localparam logic [ThrW-1:0] ThrReset = ThrW'(512);
    localparam logic [ToW-1:0]  ToReset  = ToW'(500);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DARK_THRESHOLD = 1'b0,
        CFG_LOST_TIMEOUT   = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_FIN
    } t_back_state;

    typedef struct packed {
        logic [MaskW-1:0]        mask;
        logic [CountW-1:0]       count;
        logic signed [WsumW-1:0] wsum;
        logic [TimeW-1:0]        now;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic logic signed [WsumW-1:0] sensor_weight(input int idx);
        return WsumW'(2 * idx - (SensorCount - 1));
    endfunction

endpackage

`default_nettype wire

// ===== hdl/line_position_centroid_tracker_top.sv =====
// ----------------------------------------------------------------------------
// line_position_centroid_tracker_top
// Line sensor centroid: active mask, crossing flag, Q1.14 position and a
// lost-line timer over a wrapping millisecond clock.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   input    | i_in_valid / o_in_ready    | i_sample_0..7, i_now_ms
//   output   | o_out_valid / i_out_ready  | o_position, flags, o_active_mask
//   config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// An item holds the back end from its load edge through the steps of the
// radix-16 remainder divider (BK_DIV) and its commit into the result
// register (BK_FIN), which waits while that register is full; the next
// item loads at that commit edge.
// The 2-entry queue keeps taking items until it is full while the back end
// or the result register stalls. Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module line_position_centroid_tracker_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ltc_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [ltc_pkg::CfgDataW-1:0]  i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [ltc_pkg::SampleW-1:0]   i_sample_0,
    input  wire logic [ltc_pkg::SampleW-1:0]   i_sample_1,
    input  wire logic [ltc_pkg::SampleW-1:0]   i_sample_2,
    input  wire logic [ltc_pkg::SampleW-1:0]   i_sample_3,
    input  wire logic [ltc_pkg::SampleW-1:0]   i_sample_4,
    input  wire logic [ltc_pkg::SampleW-1:0]   i_sample_5,
    input  wire logic [ltc_pkg::SampleW-1:0]   i_sample_6,
    input  wire logic [ltc_pkg::SampleW-1:0]   i_sample_7,
    input  wire logic [ltc_pkg::TimeW-1:0]     i_now_ms,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [ltc_pkg::PosW-1:0]    o_position,
    output logic                               o_line_detected,
    output logic                               o_crossing_detected,
    output logic                               o_line_lost,
    output logic [ltc_pkg::MaskW-1:0]          o_active_mask
);

    logic [ltc_pkg::ThrW-1:0]    r_threshold;
    logic [ltc_pkg::ToW-1:0]     r_timeout;
    logic [ltc_pkg::SampleW-1:0] w_samples [ltc_pkg::SensorCount];
    logic                        w_push;
    logic                        w_pop;
    ltc_pkg::t_item              w_front_item;
    ltc_pkg::t_item              w_head_item;
    ltc_pkg::t_fifo_stat         w_stat;
    ltc_pkg::t_back_state        w_back_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ltc_pkg::ThrReset;
            r_timeout   <= ltc_pkg::ToReset;
        end else if (i_cfg_we) begin
            case (ltc_pkg::t_cfg_idx'(i_cfg_index))
                ltc_pkg::CFG_DARK_THRESHOLD: r_threshold <= i_cfg_data[ltc_pkg::ThrW-1:0];
                ltc_pkg::CFG_LOST_TIMEOUT:   r_timeout   <= i_cfg_data[ltc_pkg::ToW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_samples[0] = i_sample_0;
    assign w_samples[1] = i_sample_1;
    assign w_samples[2] = i_sample_2;
    assign w_samples[3] = i_sample_3;
    assign w_samples[4] = i_sample_4;
    assign w_samples[5] = i_sample_5;
    assign w_samples[6] = i_sample_6;
    assign w_samples[7] = i_sample_7;

    ltc_front u_front (
        .i_samples   (w_samples),
        .i_now_ms    (i_now_ms),
        .i_threshold (r_threshold),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_stat      (w_stat),
        .o_push      (w_push),
        .o_item      (w_front_item)
    );

    ltc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_stat  (w_stat)
    );

    ltc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_item              (w_head_item),
        .i_stat              (w_stat),
        .o_pop               (w_pop),
        .i_timeout           (r_timeout),
        .o_valid             (o_out_valid),
        .i_ready             (i_out_ready),
        .o_position          (o_position),
        .o_line_detected     (o_line_detected),
        .o_crossing_detected (o_crossing_detected),
        .o_line_lost         (o_line_lost),
        .o_active_mask       (o_active_mask),
        .o_state             (w_back_state)
    );

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_empty_queue_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.empty |-> o_in_ready)
        else $error("input stalled with an empty queue");

    a_pop_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_stat.empty && (w_back_state != ltc_pkg::BK_DIV))
        else $error("queue popped while empty or dividing");

    a_crossing_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_crossing_detected |->
            o_line_detected && !o_line_lost &&
            ($countones(o_active_mask) >= ltc_pkg::SensorCount - 1))
        else $error("crossing flag without enough active sensors");

endmodule

`default_nettype wire

// ===== hdl/ltc_front.sv =====
// ----------------------------------------------------------------------------
// ltc_front
// Accepts an item, marks active sensors and forms mask, count and weight sum.
// ----------------------------------------------------------------------------
`default_nettype none

module ltc_front (
    input  wire logic [ltc_pkg::SampleW-1:0] i_samples [ltc_pkg::SensorCount],
    input  wire logic [ltc_pkg::TimeW-1:0]   i_now_ms,
    input  wire logic [ltc_pkg::ThrW-1:0]    i_threshold,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire ltc_pkg::t_fifo_stat         i_stat,
    output logic                             o_push,
    output ltc_pkg::t_item                   o_item
);

    always_comb begin
        logic [ltc_pkg::MaskW-1:0]        mask;
        logic [ltc_pkg::CountW-1:0]       count;
        logic signed [ltc_pkg::WsumW-1:0] wsum;
        mask  = '0;
        count = '0;
        wsum  = '0;
        for (int i = 0; i < ltc_pkg::SensorCount; i++) begin
            if (i_samples[i] < i_threshold) begin
                if (i < ltc_pkg::MaskW) begin
                    mask[i] = 1'b1;
                end
                count = count + 1'b1;
                wsum  = wsum + ltc_pkg::sensor_weight(i);
            end
        end
        o_item.mask  = mask;
        o_item.count = count;
        o_item.wsum  = wsum;
        o_item.now   = i_now_ms;
    end

    assign o_ready = !i_stat.full;
    assign o_push  = i_valid && o_ready;

endmodule

`default_nettype wire

// ===== hdl/ltc_fifo.sv =====
// ----------------------------------------------------------------------------
// ltc_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ltc_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire ltc_pkg::t_item      i_item,
    input  wire logic                i_pop,
    output ltc_pkg::t_item           o_item,
    output ltc_pkg::t_fifo_stat      o_stat
);

    ltc_pkg::t_item                r_mem [ltc_pkg::FifoDepth];
    logic [ltc_pkg::PtrW-1:0]      r_wr_ptr;
    logic [ltc_pkg::PtrW-1:0]      r_rd_ptr;
    logic [ltc_pkg::LevelW-1:0]    r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (i_pop && !i_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_level == ltc_pkg::LevelW'(ltc_pkg::FifoDepth));
    assign o_stat.empty = (r_level == '0);

endmodule

`default_nettype wire

// ===== hdl/ltc_back.sv =====
// ----------------------------------------------------------------------------
// ltc_back
// Divides the weight sum by the active count scaled by SensorCount - 1,
// tracks line loss and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ltc_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire ltc_pkg::t_item            i_item,
    input  wire ltc_pkg::t_fifo_stat       i_stat,
    output logic                           o_pop,
    input  wire logic [ltc_pkg::ToW-1:0]   i_timeout,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic signed [ltc_pkg::PosW-1:0] o_position,
    output logic                           o_line_detected,
    output logic                           o_crossing_detected,
    output logic                           o_line_lost,
    output logic [ltc_pkg::MaskW-1:0]      o_active_mask,
    output ltc_pkg::t_back_state           o_state
);

    ltc_pkg::t_back_state          r_state;
    ltc_pkg::t_back_state          n_state;
    logic [ltc_pkg::StepW-1:0]     r_step;

    ltc_pkg::t_item                r_item;
    logic [ltc_pkg::DenW-1:0]      r_den;
    logic [ltc_pkg::RemW-1:0]      r_rem;
    logic [ltc_pkg::RemW-1:0]      n_rem;
    logic [ltc_pkg::QuoW-1:0]      r_quo;
    logic [ltc_pkg::QuoW-1:0]      n_quo;
    logic                          r_sat;
    logic                          r_neg;

    logic [ltc_pkg::PosW-1:0]      r_last_pos;
    logic                          r_seen;
    logic [ltc_pkg::TimeW-1:0]     r_loss_start;
    logic                          r_lost_flag;

    logic                          r_out_valid;
    logic signed [ltc_pkg::PosW-1:0] r_pos;
    logic                          r_det;
    logic                          r_cross;
    logic                          r_lost;
    logic [ltc_pkg::MaskW-1:0]     r_mask;

    logic                          commit;
    logic                          load;
    logic [ltc_pkg::MagW-1:0]      in_mag;
    logic [ltc_pkg::DenW-1:0]      in_den;
    logic [ltc_pkg::QW-1:0]        q_val;
    logic [ltc_pkg::PosW-1:0]      pos_val;
    logic                          det_val;
    logic [ltc_pkg::TimeW-1:0]     start_val;
    logic                          lost_val;

    assign commit = (r_state == ltc_pkg::BK_FIN) && (!r_out_valid || i_ready);
    assign load   = !i_stat.empty && ((r_state == ltc_pkg::BK_IDLE) || commit);
    assign o_pop  = load;

    assign in_mag = i_item.wsum[ltc_pkg::WsumW-1] ? ltc_pkg::MagW'(-i_item.wsum)
                                                 : ltc_pkg::MagW'(i_item.wsum);
    assign in_den = ltc_pkg::DenW'(32'(i_item.count) * (ltc_pkg::SensorCount - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ltc_pkg::BK_IDLE: begin
                if (load) begin
                    n_state = ltc_pkg::BK_DIV;
                end
            end
            ltc_pkg::BK_DIV: begin
                if (r_step == ltc_pkg::StepW'(ltc_pkg::DivCycles - 1)) begin
                    n_state = ltc_pkg::BK_FIN;
                end
            end
            ltc_pkg::BK_FIN: begin
                if (commit) begin
                    n_state = load ? ltc_pkg::BK_DIV : ltc_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = ltc_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        logic [ltc_pkg::RemW-1:0] rem_v;
        logic [ltc_pkg::RemW-1:0] sh;
        logic [ltc_pkg::QuoW-1:0] quo_v;
        rem_v = r_rem;
        quo_v = r_quo;
        for (int k = 0; k < ltc_pkg::DivSteps; k++) begin
            sh = {rem_v[ltc_pkg::RemW-2:0], 1'b0};
            if (sh >= {1'b0, r_den}) begin
                rem_v = sh - {1'b0, r_den};
                quo_v = {quo_v[ltc_pkg::QuoW-2:0], 1'b1};
            end else begin
                rem_v = sh;
                quo_v = {quo_v[ltc_pkg::QuoW-2:0], 1'b0};
            end
        end
        n_rem = rem_v;
        n_quo = quo_v;
    end

    always_comb begin
        q_val = r_sat ? ltc_pkg::QOne
                      : ltc_pkg::QW'(r_quo[ltc_pkg::QuoW-1:ltc_pkg::QuoW-ltc_pkg::FracBits]);
        pos_val = r_neg ? ltc_pkg::PosW'(-{1'b0, q_val}) : ltc_pkg::PosW'(q_val);
        det_val = (r_item.count != '0);
        start_val = (r_seen && (r_loss_start == '0)) ? r_item.now : r_loss_start;
        lost_val  = r_lost_flag ||
                    ((start_val != '0) &&
                     ((r_item.now - start_val) >= ltc_pkg::TimeW'(i_timeout)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ltc_pkg::BK_IDLE;
            r_step       <= '0;
            r_last_pos   <= '0;
            r_seen       <= 1'b0;
            r_loss_start <= '0;
            r_lost_flag  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_step <= '0;
            end else if (r_state == ltc_pkg::BK_DIV) begin
                r_step <= r_step + 1'b1;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
                if (det_val) begin
                    r_last_pos   <= pos_val;
                    r_seen       <= 1'b1;
                    r_loss_start <= '0;
                    r_lost_flag  <= 1'b0;
                end else begin
                    r_loss_start <= start_val;
                    r_lost_flag  <= lost_val;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
            r_den  <= in_den;
            r_rem  <= ltc_pkg::RemW'(in_mag);
            r_quo  <= '0;
            r_sat  <= (ltc_pkg::RemW'(in_mag) >= ltc_pkg::RemW'(in_den));
            r_neg  <= i_item.wsum[ltc_pkg::WsumW-1];
        end else if (r_state == ltc_pkg::BK_DIV) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (commit) begin
            r_pos   <= det_val ? pos_val : r_last_pos;
            r_det   <= det_val;
            r_cross <= (r_item.count >= ltc_pkg::CountW'(ltc_pkg::SensorCount - 1));
            r_lost  <= det_val ? 1'b0 : lost_val;
            r_mask  <= r_item.mask;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_position          = r_pos;
    assign o_line_detected     = r_det;
    assign o_crossing_detected = r_cross;
    assign o_line_lost         = r_lost;
    assign o_active_mask       = r_mask;
    assign o_state             = r_state;

endmodule

`default_nettype wire
